>>> rtl/core/uttx_pkg.sv
package uttx_pkg;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam int FRAME_BITS = 10;
   localparam int BITS_W     = 4;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic tx_line;
      logic accepted;
      logic sending;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

>>> rtl/core/uttx_fifo.sv
module uttx_fifo #(
   parameter int QUEUE_DEPTH = 64,
   parameter int ADDR_W = $clog2(QUEUE_DEPTH),
   parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uttx_pkg::fifo_ctl_type ctl,
   input  logic [7:0]           push_data,
   output logic [CNT_W-1:0]     count,
   output logic [7:0]           head_byte
);

   logic [7:0]        mem [QUEUE_DEPTH];
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        mem_q_ff;
   logic              byp_ff, byp_in;
   logic [7:0]        byp_data_ff;

   function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      if (p == ADDR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   always_comb begin
      head_in  = ctl.pop ? ptr_inc(head_ff) : head_ff;
      tail_in  = ctl.push ? ptr_inc(tail_ff) : tail_ff;
      count_in = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
      byp_in   = ctl.push && (tail_ff == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      mem_q_ff    <= mem[head_in];
      byp_data_ff <= push_data;
   end

   assign count     = count_ff;
   assign head_byte = byp_ff ? byp_data_ff : mem_q_ff;

endmodule

>>> rtl/core/uart_tx_with_fifo_unit.sv
// each accepted request's result is registered, in the skid stage if one still waits
// one request per cycle while skid is empty; queue push, one-bit shift in that cycle
// the queue head byte is prefetched from the memory read port, so a frame loads at once
// an output register plus a skid stage keep requests flowing while a result waits
// reset: queue empty, transmitter idle, line high; queue contents undefined until written
module uart_tx_with_fifo_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  uttx_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output uttx_pkg::rsp_item_type rsp_data
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int BW     = uttx_pkg::BITS_W;
   localparam int FW     = uttx_pkg::FRAME_BITS;

   logic                   req_acc;
   logic                   rsp_pop;
   uttx_pkg::fifo_ctl_type fctl;
   logic [CNT_W-1:0]       count;
   logic [7:0]             head_byte;
   logic [7:0]             load_byte;
   logic                   load;
   logic [FW-1:0]          frame;

   logic [FW-1:0] shift_ff, shift_in;
   logic [BW-1:0] bits_ff, bits_in;
   logic          busy_ff, busy_in;
   logic          line_ff, line_in;

   uttx_pkg::rsp_item_type result;
   uttx_pkg::rsp_item_type out_ff, skid_ff;
   logic                   out_v_ff, skid_v_ff;

   uttx_fifo #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ADDR_W(ADDR_W),
      .CNT_W(CNT_W)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .ctl(fctl),
      .push_data(req_data.data_byte),
      .count(count),
      .head_byte(head_byte)
   );

   assign req_ready = !skid_v_ff;
   assign req_acc   = req_valid && req_ready;
   assign rsp_pop   = out_v_ff && rsp_ready;

   always_comb begin
      fctl.push = 1'b0;
      fctl.pop  = 1'b0;
      load      = 1'b0;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      busy_in   = busy_ff;
      line_in   = line_ff;
      result.accepted = 1'b0;
      if (req_acc) begin
         if (req_data.req_type == uttx_pkg::REQ_WRITE) begin
            fctl.push = (count != CNT_W'(QUEUE_DEPTH));
            result.accepted = fctl.push;
            load = !busy_ff && ((count != '0) || fctl.push);
         end else begin
            if (!busy_ff) begin
               line_in = 1'b1;
            end else if (bits_ff == '0) begin
               if (count == '0) begin
                  busy_in = 1'b0;
                  line_in = 1'b1;
               end else begin
                  load = 1'b1;
               end
            end else begin
               line_in  = shift_ff[0];
               shift_in = {1'b0, shift_ff[FW-1:1]};
               bits_in  = bits_ff - 1'b1;
            end
         end
      end
      fctl.pop  = load;
      // an empty queue hands the byte being written straight to the framer
      load_byte = (count == '0) ? req_data.data_byte : head_byte;
      frame     = {1'b1, load_byte, 1'b0};
      if (load) begin
         busy_in  = 1'b1;
         line_in  = frame[0];
         shift_in = {1'b0, frame[FW-1:1]};
         bits_in  = BW'(FW - 1);
      end
      result.tx_line = line_in;
      result.sending = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         bits_ff  <= '0;
         busy_ff  <= 1'b0;
         line_ff  <= 1'b1;
      end else begin
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         busy_ff  <= busy_in;
         line_ff  <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_pop) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end else if (req_acc) begin
            out_ff <= result;
         end else begin
            out_v_ff <= 1'b0;
         end
      end else if (req_acc) begin
         if (out_v_ff) begin
            skid_ff   <= result;
            skid_v_ff <= 1'b1;
         end else begin
            out_ff   <= result;
            out_v_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/core/uttx_checker.sv
module uttx_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input uttx_pkg::rsp_item_type rsp_data
);

   // no result pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // idle transmitter leaves the line high
   a_idle_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sending |-> rsp_data.tx_line)
      else $error("line low while idle");

   // empty output side always takes a request
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with no result pending");

   // every accepted request leaves a result waiting
   a_acc_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request left no result");

endmodule

bind uart_tx_with_fifo_unit uttx_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

>>> tb/sv/tb_uart_tx_with_fifo_unit.sv
`timescale 1ns / 100ps

module tb_uart_tx_with_fifo_unit;

   localparam int QUEUE_DEPTH = 64;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   uttx_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   uttx_pkg::rsp_item_type rsp_data;

   // transmitter state as predicted
   logic [7:0]   byte_queue[$];
   logic [9:0]   frame_bits = '0;
   logic [3:0]   bits_remaining = '0;
   logic         frame_active = 1'b0;
   logic         line_level = 1'b1;

   uttx_pkg::rsp_item_type pending_line_states[$];
   int           src_idle_max = 15;
   int           snk_idle_max = 15;
   int           hold_off_cycles = 0;
   int           fail_count = 0;
   int           checked_count = 0;

   uart_tx_with_fifo_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void load_frame(input logic [7:0] value);
      frame_bits = {1'b1, value, 1'b0};
      bits_remaining = 4'd10;
   endfunction

   function automatic void shift_out();
      line_level = frame_bits[0];
      frame_bits = frame_bits >> 1;
      bits_remaining = bits_remaining - 4'd1;
   endfunction

   function automatic uttx_pkg::rsp_item_type predict_line_state(
      input uttx_pkg::req_item_type item
   );
      uttx_pkg::rsp_item_type result;
      result.accepted = 1'b0;
      if (item.req_type == uttx_pkg::REQ_WRITE) begin
         if (byte_queue.size() < QUEUE_DEPTH) begin
            byte_queue.push_back(item.data_byte);
            result.accepted = 1'b1;
         end
         if (!frame_active && byte_queue.size() != 0) begin
            load_frame(byte_queue.pop_front());
            frame_active = 1'b1;
            shift_out();
         end
      end else if (!frame_active) begin
         line_level = 1'b1;
      end else if (bits_remaining == 4'd0 && byte_queue.size() == 0) begin
         frame_active = 1'b0;
         line_level = 1'b1;
      end else begin
         if (bits_remaining == 4'd0) begin
            load_frame(byte_queue.pop_front());
         end
         shift_out();
      end
      result.tx_line = line_level;
      result.sending = frame_active;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", checked_count, what);
      fail_count++;
   endtask

   task automatic send_request(input logic kind, input logic [7:0] value);
      uttx_pkg::req_item_type item;
      int                     gap;
      item.req_type = kind;
      item.data_byte = value;
      gap = $urandom_range(0, src_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_line_states.push_back(predict_line_state(item));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(uttx_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_idle_tick();
      send_ticks(1);
   endtask

   task automatic test_single_frame();
      // start bit, eight data bits, stop bit, then the frame ends
      send_request(uttx_pkg::REQ_WRITE, 8'h00);
      send_ticks(10);
   endtask

   task automatic test_queued_frame();
      // second byte starts on the tick after the first stop bit
      send_request(uttx_pkg::REQ_WRITE, 8'hFF);
      send_request(uttx_pkg::REQ_WRITE, 8'hA5);
      send_ticks(12);
   endtask

   task automatic test_random_traffic();
      int n;
      for (n = 0; n < 360; n++) begin
         if (n % 60 == 0) begin
            src_idle_max = ($urandom_range(0, 1) == 1) ? 15 : 0;
            snk_idle_max = ($urandom_range(0, 1) == 1) ? 15 : 0;
         end
         if ($urandom_range(0, 49) == 0) begin
            repeat ($urandom_range(3, 6))
               send_request(uttx_pkg::REQ_WRITE, 8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 99) < 10) begin
            send_request(uttx_pkg::REQ_WRITE, 8'($urandom_range(0, 255)));
         end else begin
            send_ticks(1);
         end
      end
   endtask

   task automatic test_queue_full();
      // receiver holds off while writes keep coming, then the queue overflows
      src_idle_max = 0;
      snk_idle_max = 15;
      hold_off_cycles = 80;
      repeat (70) send_request(uttx_pkg::REQ_WRITE, 8'($urandom_range(0, 255)));
      src_idle_max = 15;
      send_ticks(12);
   endtask

   initial begin : result_checker
      int                     stall;
      uttx_pkg::rsp_item_type want;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = $urandom_range(0, snk_idle_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_line_states.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_line_states.pop_front();
            if (rsp_data.tx_line !== want.tx_line)
               report_mismatch($sformatf("tx_line %b, predicted %b",
                                         rsp_data.tx_line, want.tx_line));
            if (rsp_data.accepted !== want.accepted)
               report_mismatch($sformatf("accepted %b, predicted %b",
                                         rsp_data.accepted, want.accepted));
            if (rsp_data.sending !== want.sending)
               report_mismatch($sformatf("sending %b, predicted %b",
                                         rsp_data.sending, want.sending));
         end
         checked_count++;
      end
   end

   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_tick();
      test_single_frame();
      test_queued_frame();
      test_random_traffic();
      test_queue_full();
      req_valid <= 1'b0;
      while (pending_line_states.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
